// ----- design/gsp_pkg.sv -----
// ---------------------------------------------------------------------------
// gsp_pkg
// Shared types and constants for the grid path search block.
// ---------------------------------------------------------------------------
`default_nettype none

package gsp_pkg;

  localparam int MAX_SIDE       = 64;
  localparam int HEUR_FRAC_BITS = 8;
  localparam int COORD_W        = $clog2(MAX_SIDE);
  localparam int CELLS          = MAX_SIDE * MAX_SIDE;
  localparam int ID_W           = 2 * COORD_W;
  localparam int CNT_W          = ID_W + 1;
  localparam int SIDE_W         = COORD_W + 1;
  localparam int G_W            = ID_W;
  localparam int ORD_W          = CNT_W;
  localparam int SQ_W           = 2 * COORD_W + 1;
  localparam int RES_W          = (SQ_W + 2 * HEUR_FRAC_BITS + 1) / 2;
  localparam int RAD_W          = 2 * RES_W;
  localparam int F_W            = G_W + HEUR_FRAC_BITS + 1;
  localparam int MAP_W          = 7;
  localparam int IDX_W          = 12;
  localparam int MAP_RESET      = 64;

  typedef enum logic [1:0] {
    KIND_TILE   = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_UNVISITED = 2'd0,
    ST_OPEN      = 2'd1,
    ST_CLOSED    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_UP    = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  typedef struct packed {
    status_e            status;
    logic [G_W-1:0]     g;
    dir_e               dir;
    logic [ORD_W-1:0]   ord;
    logic [F_W-1:0]     f;
  } cell_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               is_road;
    logic [COORD_W-1:0] goal_col;
    logic [COORD_W-1:0] goal_row;
    logic [IDX_W-1:0]   path_index;
  } item_t;

  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
  } sq_req_t;

  typedef struct packed {
    logic               done;
    logic [RES_W-1:0]   root;
  } sq_rsp_t;

endpackage

`default_nettype wire

// ----- design/gsp_isqrt.sv -----
// ---------------------------------------------------------------------------
// gsp_isqrt
// Euclidean distance in fixed point, one root bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module gsp_isqrt
  import gsp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire sq_req_t req_i,
  output sq_rsp_t      rsp_o
);

  localparam int REM_W = RES_W + 3;
  localparam int STEP_W = $clog2(RES_W + 1);

  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [RES_W-1:0]  root_q, root_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [COORD_W-1:0] dx, dy;
  logic [SQ_W-1:0]    sum;
  logic [REM_W-1:0]   rem_sh, trial;

  always_comb begin
    dx     = (req_i.ax > req_i.bx) ? req_i.ax - req_i.bx : req_i.bx - req_i.ax;
    dy     = (req_i.ay > req_i.by) ? req_i.ay - req_i.by : req_i.by - req_i.ay;
    sum    = SQ_W'(dx) * SQ_W'(dx) + SQ_W'(dy) * SQ_W'(dy);
    rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rad_d  = RAD_W'(sum) << (2 * HEUR_FRAC_BITS);
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = rad_q << 2;
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[RES_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[RES_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == STEP_W'(RES_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

`default_nettype wire

// ----- design/gsp_core.sv -----
// ---------------------------------------------------------------------------
// gsp_core
// Sequencer, cell memories, open list scan and path store.
// ---------------------------------------------------------------------------
`default_nettype none

module gsp_core
  import gsp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire item_t              item_i,
  input  wire logic [MAP_W-1:0]   map_size_i,
  output logic                    busy_o,
  output logic                    result_valid_o,
  output logic                    found_o,
  output logic [CNT_W-1:0]        path_length_o,
  output logic                    entry_valid_o,
  output logic [COORD_W-1:0]      path_col_o,
  output logic [COORD_W-1:0]      path_row_o
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CHECK, S_HWAIT, S_SCAN, S_POP, S_POP2,
    S_NB, S_NB_CHK, S_NEXT, S_RB, S_RB_W
  } state_e;

  state_e state_q, state_d;

  // memories
  logic        road_mem [CELLS];
  cell_t       cell_mem [CELLS];
  logic [ID_W-1:0] open_mem [CELLS];
  logic [ID_W-1:0] path_mem [CELLS];

  logic            rm_we, rm_wdata, rm_rdata_q;
  logic [ID_W-1:0] rm_waddr, rm_raddr;
  logic            cm_we;
  cell_t           cm_wdata, cm_rdata_q;
  logic [ID_W-1:0] cm_waddr, cm_raddr;
  logic            om_we;
  logic [ID_W-1:0] om_waddr, om_raddr, om_wdata, om_rdata_q;
  logic            pm_we;
  logic [ID_W-1:0] pm_waddr, pm_raddr, pm_wdata, pm_rdata_q;

  always_ff @(posedge clk_i) begin
    if (rm_we) road_mem[rm_waddr] <= rm_wdata;
    rm_rdata_q <= road_mem[rm_raddr];
    if (cm_we) cell_mem[cm_waddr] <= cm_wdata;
    cm_rdata_q <= cell_mem[cm_raddr];
    if (om_we) open_mem[om_waddr] <= om_wdata;
    om_rdata_q <= open_mem[om_raddr];
    if (pm_we) path_mem[pm_waddr] <= pm_wdata;
    pm_rdata_q <= path_mem[pm_raddr];
  end

  // sequencer registers
  logic               rst_sweep_q, rst_sweep_d;
  logic [ID_W-1:0]    clr_q, clr_d;
  logic [COORD_W-1:0] sc_q, sc_d, sr_q, sr_d, gc_q, gc_d, gr_q, gr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [ORD_W-1:0]   ord_q, ord_d;
  logic [CNT_W-1:0]   iss_q, iss_d;
  logic               v1_q, v1_d, v2_q, v2_d;
  logic [ID_W-1:0]    k1_q, k1_d, k2_q, k2_d, id2_q, id2_d;
  logic               have_q, have_d;
  logic [ID_W-1:0]    best_k_q, best_k_d, best_id_q, best_id_d;
  cell_t              best_q, best_d;
  logic [ID_W-1:0]    node_q, node_d, nid_q, nid_d;
  logic [G_W-1:0]     gnew_q, gnew_d;
  dir_e               dir_q, dir_d;
  logic               from_start_q, from_start_d;
  logic [ID_W-1:0]    rb_i_q, rb_i_d;
  logic [CNT_W-1:0]   len_q, len_d, rb_len_q, rb_len_d;
  logic               found_q, found_d;
  logic               res_q, res_d;
  logic               ev_q, ev_d;

  sq_req_t sq_req;
  sq_rsp_t sq_rsp;

  gsp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sq_req),
    .rsp_o  (sq_rsp)
  );

  logic [SIDE_W-1:0]  side;
  logic [COORD_W-1:0] ncol, nrow;
  logic               nb_ok;
  logic [ID_W-1:0]    nb_id;
  logic               better;
  logic [G_W-1:0]     gdiff;

  always_comb begin
    if (map_size_i < MAP_W'(2)) side = SIDE_W'(2);
    else if (map_size_i > MAP_W'(MAX_SIDE)) side = SIDE_W'(MAX_SIDE);
    else side = SIDE_W'(map_size_i);
  end

  always_comb begin
    ncol  = node_q[COORD_W-1:0];
    nrow  = node_q[ID_W-1:COORD_W];
    nb_ok = 1'b0;
    nb_id = node_q;
    unique case (dir_q)
      DIR_LEFT: begin
        nb_ok = (ncol != '0);
        nb_id = node_q - ID_W'(1);
      end
      DIR_UP: begin
        nb_ok = (nrow != '0);
        nb_id = node_q - ID_W'(MAX_SIDE);
      end
      DIR_RIGHT: begin
        nb_ok = (SIDE_W'(ncol) + SIDE_W'(1)) < side;
        nb_id = node_q + ID_W'(1);
      end
      DIR_DOWN: begin
        nb_ok = (SIDE_W'(nrow) + SIDE_W'(1)) < side;
        nb_id = node_q + ID_W'(MAX_SIDE);
      end
      default: ;
    endcase
  end

  always_comb begin
    better = !have_q || (cm_rdata_q.f < best_q.f) ||
             ((cm_rdata_q.f == best_q.f) && (cm_rdata_q.ord < best_q.ord));
    gdiff  = cm_rdata_q.g - gnew_q;
  end

  always_comb begin
    state_d      = state_q;
    rst_sweep_d  = rst_sweep_q;
    clr_d        = clr_q;
    sc_d = sc_q; sr_d = sr_q; gc_d = gc_q; gr_d = gr_q;
    cnt_d        = cnt_q;
    ord_d        = ord_q;
    iss_d        = iss_q;
    v1_d         = 1'b0;
    v2_d         = 1'b0;
    k1_d         = k1_q;
    k2_d         = k2_q;
    id2_d        = id2_q;
    have_d       = have_q;
    best_k_d     = best_k_q;
    best_id_d    = best_id_q;
    best_d       = best_q;
    node_d       = node_q;
    nid_d        = nid_q;
    gnew_d       = gnew_q;
    dir_d        = dir_q;
    from_start_d = from_start_q;
    rb_i_d       = rb_i_q;
    rb_len_d     = rb_len_q;
    len_d        = len_q;
    found_d      = found_q;
    res_d        = 1'b0;
    ev_d         = ev_q;
    rm_we = 1'b0; rm_waddr = '0; rm_wdata = 1'b0; rm_raddr = '0;
    cm_we = 1'b0; cm_waddr = '0; cm_wdata = '0;   cm_raddr = '0;
    om_we = 1'b0; om_waddr = '0; om_wdata = '0;   om_raddr = '0;
    pm_we = 1'b0; pm_waddr = '0; pm_wdata = '0;   pm_raddr = '0;
    sq_req = '0;

    unique case (state_q)
      S_CLR: begin
        cm_we    = 1'b1;
        cm_waddr = clr_q;
        cm_wdata = '0;
        if (rst_sweep_q) begin
          rm_we    = 1'b1;
          rm_waddr = clr_q;
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == ID_W'(CELLS - 1)) begin
          state_d     = rst_sweep_q ? S_IDLE : S_CHECK;
          rst_sweep_d = 1'b0;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          ev_d = 1'b0;
          case (item_i.kind)
            KIND_TILE: begin
              rm_we    = 1'b1;
              rm_waddr = {item_i.row, item_i.col};
              rm_wdata = item_i.is_road;
              res_d    = 1'b1;
            end
            KIND_SEARCH: begin
              sc_d = item_i.col; sr_d = item_i.row;
              gc_d = item_i.goal_col; gr_d = item_i.goal_row;
              clr_d   = '0;
              state_d = S_CLR;
            end
            KIND_READ: begin
              pm_raddr = item_i.path_index;
              ev_d     = CNT_W'(item_i.path_index) < len_q;
              res_d    = 1'b1;
            end
            default: res_d = 1'b1;
          endcase
        end
      end
      S_CHECK: begin
        if (SIDE_W'(sc_q) >= side || SIDE_W'(sr_q) >= side ||
            SIDE_W'(gc_q) >= side || SIDE_W'(gr_q) >= side) begin
          found_d = 1'b0;
          len_d   = '0;
          res_d   = 1'b1;
          state_d = S_IDLE;
        end else begin
          sq_req       = '{start: 1'b1, ax: sc_q, ay: sr_q, bx: gc_q, by: gr_q};
          nid_d        = {sr_q, sc_q};
          gnew_d       = '0;
          dir_d        = DIR_LEFT;
          cnt_d        = '0;
          ord_d        = '0;
          from_start_d = 1'b1;
          state_d      = S_HWAIT;
        end
      end
      S_HWAIT: begin
        if (sq_rsp.done) begin
          cm_we    = 1'b1;
          cm_waddr = nid_q;
          cm_wdata = '{status: ST_OPEN, g: gnew_q, dir: dir_q, ord: ord_q,
                       f: (F_W'(gnew_q) << HEUR_FRAC_BITS) + F_W'(sq_rsp.root)};
          om_we    = 1'b1;
          om_waddr = cnt_q[ID_W-1:0];
          om_wdata = nid_q;
          cnt_d    = cnt_q + 1'b1;
          ord_d    = ord_q + 1'b1;
          if (from_start_q) begin
            from_start_d = 1'b0;
            iss_d        = '0;
            have_d       = 1'b0;
            state_d      = S_SCAN;
          end else begin
            state_d = S_NEXT;
          end
        end
      end
      S_SCAN: begin
        if (cnt_q == '0) begin
          found_d = 1'b0;
          len_d   = '0;
          res_d   = 1'b1;
          state_d = S_IDLE;
        end else begin
          if (iss_q < cnt_q) begin
            om_raddr = iss_q[ID_W-1:0];
            v1_d     = 1'b1;
            k1_d     = iss_q[ID_W-1:0];
            iss_d    = iss_q + 1'b1;
          end
          if (v1_q) begin
            cm_raddr = om_rdata_q;
            id2_d    = om_rdata_q;
            k2_d     = k1_q;
            v2_d     = 1'b1;
          end
          if (v2_q && better) begin
            have_d    = 1'b1;
            best_k_d  = k2_q;
            best_id_d = id2_q;
            best_d    = cm_rdata_q;
          end
          if (iss_q >= cnt_q && !v1_q && !v2_q) state_d = S_POP;
        end
      end
      S_POP: begin
        om_raddr = ID_W'(cnt_q - 1'b1);
        cnt_d    = cnt_q - 1'b1;
        state_d  = S_POP2;
      end
      S_POP2: begin
        om_we    = 1'b1;
        om_waddr = best_k_q;
        om_wdata = om_rdata_q;
        if (best_id_q == {gr_q, gc_q}) begin
          rb_len_d = CNT_W'(best_q.g) + 1'b1;
          rb_i_d   = best_q.g;
          node_d   = best_id_q;
          state_d  = S_RB;
        end else begin
          cm_we           = 1'b1;
          cm_waddr        = best_id_q;
          cm_wdata        = best_q;
          cm_wdata.status = ST_CLOSED;
          node_d          = best_id_q;
          gnew_d          = best_q.g + 1'b1;
          dir_d           = DIR_LEFT;
          state_d         = S_NB;
        end
      end
      S_NB: begin
        if (nb_ok) begin
          cm_raddr = nb_id;
          rm_raddr = nb_id;
          nid_d    = nb_id;
          state_d  = S_NB_CHK;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_NB_CHK: begin
        state_d = S_NEXT;
        if (rm_rdata_q && cm_rdata_q.status != ST_CLOSED) begin
          if (cm_rdata_q.status == ST_UNVISITED) begin
            sq_req  = '{start: 1'b1, ax: nid_q[COORD_W-1:0], ay: nid_q[ID_W-1:COORD_W],
                        bx: gc_q, by: gr_q};
            state_d = S_HWAIT;
          end else if (gnew_q < cm_rdata_q.g) begin
            cm_we    = 1'b1;
            cm_waddr = nid_q;
            cm_wdata = cm_rdata_q;
            cm_wdata.g   = gnew_q;
            cm_wdata.dir = dir_q;
            cm_wdata.f   = cm_rdata_q.f - (F_W'(gdiff) << HEUR_FRAC_BITS);
          end
        end
      end
      S_NEXT: begin
        if (dir_q == DIR_DOWN) begin
          iss_d   = '0;
          have_d  = 1'b0;
          state_d = S_SCAN;
        end else begin
          dir_d   = dir_e'(dir_q + 2'd1);
          state_d = S_NB;
        end
      end
      S_RB: begin
        pm_we    = 1'b1;
        pm_waddr = rb_i_q;
        pm_wdata = node_q;
        if (rb_i_q == '0) begin
          found_d = 1'b1;
          len_d   = rb_len_q;
          res_d   = 1'b1;
          state_d = S_IDLE;
        end else begin
          cm_raddr = node_q;
          state_d  = S_RB_W;
        end
      end
      S_RB_W: begin
        unique case (cm_rdata_q.dir)
          DIR_LEFT:  node_d = node_q + ID_W'(1);
          DIR_UP:    node_d = node_q + ID_W'(MAX_SIDE);
          DIR_RIGHT: node_d = node_q - ID_W'(1);
          DIR_DOWN:  node_d = node_q - ID_W'(MAX_SIDE);
          default:   node_d = node_q;
        endcase
        rb_i_d  = rb_i_q - 1'b1;
        state_d = S_RB;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      rst_sweep_q  <= 1'b1;
      clr_q        <= '0;
      cnt_q        <= '0;
      ord_q        <= '0;
      iss_q        <= '0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      have_q       <= 1'b0;
      from_start_q <= 1'b0;
      len_q        <= '0;
      found_q      <= 1'b0;
      res_q        <= 1'b0;
      ev_q         <= 1'b0;
      dir_q        <= DIR_LEFT;
    end else begin
      state_q      <= state_d;
      rst_sweep_q  <= rst_sweep_d;
      clr_q        <= clr_d;
      cnt_q        <= cnt_d;
      ord_q        <= ord_d;
      iss_q        <= iss_d;
      v1_q         <= v1_d;
      v2_q         <= v2_d;
      have_q       <= have_d;
      from_start_q <= from_start_d;
      len_q        <= len_d;
      found_q      <= found_d;
      res_q        <= res_d;
      ev_q         <= ev_d;
      dir_q        <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sc_q <= sc_d; sr_q <= sr_d; gc_q <= gc_d; gr_q <= gr_d;
    k1_q      <= k1_d;
    k2_q      <= k2_d;
    id2_q     <= id2_d;
    best_k_q  <= best_k_d;
    best_id_q <= best_id_d;
    best_q    <= best_d;
    node_q    <= node_d;
    nid_q     <= nid_d;
    gnew_q    <= gnew_d;
    rb_i_q    <= rb_i_d;
    rb_len_q  <= rb_len_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = res_q;
  assign found_o        = found_q;
  assign path_length_o  = len_q;
  assign entry_valid_o  = ev_q;
  assign path_col_o     = ev_q ? pm_rdata_q[COORD_W-1:0] : '0;
  assign path_row_o     = ev_q ? pm_rdata_q[ID_W-1:COORD_W] : '0;

  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && item_i.kind == KIND_SEARCH |=> busy_o)
    else $error("search transaction did not raise busy");

  a_open_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CELLS))
    else $error("open list overflow");

  a_sqrt_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_rsp.done |-> state_q == S_HWAIT)
    else $error("distance result outside wait state");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q) != S_CLR)
    else $error("result during clearing sweep");

endmodule

`default_nettype wire

// ----- design/grid_astar_path_search.sv -----
// ---------------------------------------------------------------------------
// grid_astar_path_search
// A* search on a square road grid with tile load and path read transactions.
// ---------------------------------------------------------------------------
// tile write, path read: result registered in the cycle after start, one transaction per cycle while idle
// search: status clear sweep, start cell opened through the root unit, then per
//   expansion a scan of the open list and removal of the best entry, a check per
//   neighbor and a run of the shared root unit per new cell, then a path walk back
// reset: a sweep over all cells clears road map and status, busy high meanwhile
// the receiver cannot stall: each result strobe lasts one cycle
`default_nettype none

module grid_astar_path_search
  import gsp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [1:0]         kind_i,
  input  wire logic [COORD_W-1:0] col_i,
  input  wire logic [COORD_W-1:0] row_i,
  input  wire logic               is_road_i,
  input  wire logic [COORD_W-1:0] goal_col_i,
  input  wire logic [COORD_W-1:0] goal_row_i,
  input  wire logic [IDX_W-1:0]   path_index_i,
  output logic                    result_valid_o,
  output logic                    found_o,
  output logic [CNT_W-1:0]        path_length_o,
  output logic                    entry_valid_o,
  output logic [COORD_W-1:0]      path_col_o,
  output logic [COORD_W-1:0]      path_row_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [MAP_W-1:0] map_size_q;
  item_t            item;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_size_q <= MAP_W'(MAP_RESET);
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      map_size_q <= pwdata[MAP_W-1:0];
    end
  end

  assign prdata = (paddr == 3'd0) ? {{(32 - MAP_W){1'b0}}, map_size_q} : 32'd0;

  assign item = '{kind: kind_i, col: col_i, row: row_i, is_road: is_road_i,
                  goal_col: goal_col_i, goal_row: goal_row_i,
                  path_index: path_index_i};

  gsp_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .item_i         (item),
    .map_size_i     (map_size_q),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .found_o        (found_o),
    .path_length_o  (path_length_o),
    .entry_valid_o  (entry_valid_o),
    .path_col_o     (path_col_o),
    .path_row_o     (path_row_o)
  );

endmodule

`default_nettype wire
